// ===== sv/hcm_pkg.sv =====
`timescale 1ns / 1ps

package hcm_pkg;

  typedef enum logic [1:0] {
    FUNC_KEY    = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT
  } state_e;

  // Modifier bit order is control, shift, super, alt (msb to lsb).
  localparam int unsigned ModCtrl  = 3;
  localparam int unsigned ModShift = 2;
  localparam int unsigned ModSuper = 1;
  localparam int unsigned ModAlt   = 0;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  mods;
    logic [7:0]  key;
  } entry_t;

  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [3:0]  mods;
    logic [7:0]  key;
    logic [15:0] hit_id;
  } token_t;

  typedef struct packed {
    logic   add;
    logic   remove;
    logic   clear;
    logic   take;
    logic   give;
    entry_t arg;
  } cell_cmd_t;

endpackage

// ===== sv/hcm_cell.sv =====
`timescale 1ns / 1ps

module hcm_cell
  import hcm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  logic      prv_valid_i,
  input  logic      nxt_valid_i,
  input  entry_t    nxt_entry_i,
  input  token_t    tok_i,
  output token_t    tok_o,
  output logic      valid_o,
  output entry_t    entry_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  token_t tok_q, tok_d;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.add && !valid_q && prv_valid_i) begin
      valid_d = 1'b1;
      entry_d = cmd_i.arg;
    end else if (cmd_i.remove && valid_q && (entry_q.id == cmd_i.arg.id)) begin
      valid_d = 1'b0;
    end else if (cmd_i.take && !valid_q && nxt_valid_i) begin
      valid_d = 1'b1;
      entry_d = nxt_entry_i;
    end else if (cmd_i.give && valid_q && !prv_valid_i) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.hit && valid_q && (entry_q.key == tok_i.key) &&
        (entry_q.mods == tok_i.mods)) begin
      tok_d.hit    = 1'b1;
      tok_d.hit_id = entry_q.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ===== sv/hotkey_combo_matcher_top.sv =====
`timescale 1ns / 1ps
// Add, clear, remove and key events that need no table lookup give their result in the cycle
// after the transfer. A key press that is looked up gives its registered result once the query
// has walked the row of entry cells, which it does one cell per cycle.
// A remove blocks new input while the row compacts in odd-even rounds.
// Other operations take one item per cycle when the output side keeps up.
// Reset clears the modifier flags, all entry valid bits and the output valid flag.

module hotkey_combo_matcher_top
  import hcm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  key_code_i,
  input  logic        is_release_i,
  input  logic [15:0] combo_id_i,
  input  logic        need_ctrl_i,
  input  logic        need_shift_i,
  input  logic        need_super_i,
  input  logic        need_alt_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [15:0] hit_id_o,
  output logic        send_dummy_release_o,
  output logic        table_full_o
);

  localparam int unsigned CntW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [7:0] KeyLwin   = 8'h5B;
  localparam logic [7:0] KeyRwin   = 8'h5C;
  localparam logic [7:0] KeyAlt    = 8'h12;
  localparam logic [7:0] KeyLalt   = 8'hA4;
  localparam logic [7:0] KeyRalt   = 8'hA5;
  localparam logic [7:0] KeyShift  = 8'h10;
  localparam logic [7:0] KeyLshift = 8'hA0;
  localparam logic [7:0] KeyRshift = 8'hA1;
  localparam logic [7:0] KeyCtrl   = 8'h11;
  localparam logic [7:0] KeyLctrl  = 8'hA2;
  localparam logic [7:0] KeyRctrl  = 8'hA3;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0] held_q, held_d;

  logic        out_valid_q, out_valid_d;
  logic        hit_q, hit_d;
  logic [15:0] hit_id_q, hit_id_d;
  logic        dummy_q, dummy_d;
  logic        full_q, full_d;

  logic      accept;
  func_e     func;
  logic      is_super, is_alt, is_shift, is_ctrl, is_mod;
  logic      lookup;
  cell_cmd_t base_cmd;
  token_t    inject;

  logic   [TABLE_ENTRIES-1:0] valid_vec;
  entry_t                     entry_vec [TABLE_ENTRIES];
  token_t                     tok_vec   [TABLE_ENTRIES];
  logic   [TABLE_ENTRIES-1:0] tok_vld_vec;
  token_t                     tok_last;

  assign accept   = in_valid_i && in_ready_o;
  assign func     = func_e'(func_i);
  assign tok_last = tok_vec[TABLE_ENTRIES-1];

  assign is_super = (key_code_i == KeyLwin) || (key_code_i == KeyRwin);
  assign is_alt   = (key_code_i == KeyAlt) || (key_code_i == KeyLalt) ||
                    (key_code_i == KeyRalt);
  assign is_shift = (key_code_i == KeyShift) || (key_code_i == KeyLshift) ||
                    (key_code_i == KeyRshift);
  assign is_ctrl  = (key_code_i == KeyCtrl) || (key_code_i == KeyLctrl) ||
                    (key_code_i == KeyRctrl);
  assign is_mod   = is_super || is_alt || is_shift || is_ctrl;

  assign lookup = (func == FUNC_KEY) && !is_mod && !is_release_i &&
                  (held_q[ModSuper] || held_q[ModAlt] || held_q[ModCtrl]);

  always_comb begin
    inject        = '0;
    inject.vld    = accept && lookup;
    inject.mods   = held_q;
    inject.key    = key_code_i;
  end

  always_comb begin
    base_cmd          = '0;
    base_cmd.arg.id   = combo_id_i;
    base_cmd.arg.mods = {need_ctrl_i, need_shift_i, need_super_i, need_alt_i};
    base_cmd.arg.key  = key_code_i;
    if (accept) begin
      unique case (func)
        FUNC_KEY:    base_cmd.add = 1'b0;
        FUNC_ADD:    base_cmd.add = !valid_vec[TABLE_ENTRIES-1];
        FUNC_REMOVE: base_cmd.remove = 1'b1;
        FUNC_CLEAR:  base_cmd.clear = 1'b1;
      endcase
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    localparam logic Par = 1'(i % 2);
    cell_cmd_t cmd;
    logic      prv_valid;
    logic      nxt_valid;
    entry_t    nxt_entry;
    token_t    tok_in;

    if (i == 0) begin : g_head
      assign prv_valid = 1'b1;
      assign tok_in    = inject;
    end else begin : g_body
      assign prv_valid = valid_vec[i-1];
      assign tok_in    = tok_vec[i-1];
    end

    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign nxt_valid = 1'b0;
      assign nxt_entry = entry_vec[i];
    end else begin : g_inner
      assign nxt_valid = valid_vec[i+1];
      assign nxt_entry = entry_vec[i+1];
    end

    always_comb begin
      cmd      = base_cmd;
      cmd.take = (state_q == ST_COMPACT) && (cnt_q[0] == Par) &&
                 (i < TABLE_ENTRIES - 1);
      cmd.give = (state_q == ST_COMPACT) && (cnt_q[0] != Par) && (i > 0);
    end

    hcm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .prv_valid_i (prv_valid),
      .nxt_valid_i (nxt_valid),
      .nxt_entry_i (nxt_entry),
      .tok_i       (tok_in),
      .tok_o       (tok_vec[i]),
      .valid_o     (valid_vec[i]),
      .entry_o     (entry_vec[i])
    );

    assign tok_vld_vec[i] = tok_vec[i].vld;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    hit_id_d    = hit_id_q;
    dummy_d     = dummy_q;
    full_d      = full_q;
    in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (lookup) begin
            state_d = ST_SCAN;
          end else begin
            out_valid_d = 1'b1;
            hit_d       = 1'b0;
            hit_id_d    = '0;
            dummy_d     = 1'b0;
            full_d      = (func == FUNC_ADD) && valid_vec[TABLE_ENTRIES-1];
            if (func == FUNC_REMOVE) begin
              state_d = ST_COMPACT;
              cnt_d   = '0;
            end
          end
          if (func == FUNC_KEY) begin
            if (is_super) held_d[ModSuper] = !is_release_i;
            if (is_alt)   held_d[ModAlt]   = !is_release_i;
            if (is_shift) held_d[ModShift] = !is_release_i;
            if (is_ctrl)  held_d[ModCtrl]  = !is_release_i;
          end
        end
      end
      ST_SCAN: begin
        if (tok_last.vld) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          hit_d       = tok_last.hit;
          hit_id_d    = tok_last.hit_id;
          dummy_d     = tok_last.hit && tok_last.mods[ModSuper];
          full_d      = 1'b0;
        end
      end
      ST_COMPACT: begin
        if (cnt_q == CntW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    hit_id_q <= hit_id_d;
    dummy_q  <= dummy_d;
    full_q   <= full_d;
  end

  assign out_valid_o          = out_valid_q;
  assign hit_o                = hit_q;
  assign hit_id_o             = hit_id_q;
  assign send_dummy_release_o = dummy_q;
  assign table_full_o         = full_q;

  a_prefix_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (((valid_vec >> 1) & ~valid_vec) == '0))
    else $error("Valid entries are not a contiguous prefix.");

  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld_vec))
    else $error("More than one query token in the cell row.");

  a_idle_no_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (tok_vld_vec == '0))
    else $error("Input ready while a query is in flight.");

  a_dummy_needs_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_dummy_release_o) |-> hit_o)
    else $error("Dummy release requested without a hit.");

  a_full_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (!hit_o && (hit_id_o == '0)))
    else $error("Table full result carries a hit.");

endmodule
